/* rtl/pwt_pkg.sv */
// ----------------------------------------------------------------------------
// pwt_pkg: shared types and constants
// Command kinds, line phases, register indexes and the control structs that
// pass between the front and back parts of the single-wire transmitter.
// ----------------------------------------------------------------------------
`default_nettype none

package pwt_pkg;

  // Widths of the fixed fields
  localparam int KIND_W  = 2;
  localparam int UNIT_W  = 10;
  localparam int IDLE_W  = 12;
  localparam int TICK_W  = 12;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 12;
  localparam int OUT_W   = 8;

  // Reset values of the configuration registers
  localparam logic [UNIT_W-1:0] UNIT_TICKS_RST = 10'd7;
  localparam logic [IDLE_W-1:0] IDLE_TICKS_RST = 12'd110;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_UNIT_TICKS = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_IDLE_TICKS = 2'd1;

  // Kind of an input word
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_LOW   = 2'd2,
    KIND_HIGH  = 2'd3
  } pwt_kind_e;

  // Phase of the line sequencer
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HOLD = 2'd1,
    PH_HIGH = 2'd2,
    PH_LOW  = 2'd3
  } pwt_phase_e;

  // Timing configuration handed to the back part
  typedef struct packed {
    logic [UNIT_W-1:0] unit_ticks;
    logic [IDLE_W-1:0] idle_ticks;
  } pwt_cfg_t;

  // Queue handshake from front to back
  typedef struct packed {
    logic      valid;
    pwt_kind_e kind;
  } pwt_cmd_t;

endpackage

`default_nettype wire

/* rtl/pwt_front.sv */
// ----------------------------------------------------------------------------
// pwt_front: input acceptance and command queue
// Classifies each input word and keeps up to two words in a small queue so
// the input side can keep accepting while the output side stalls, until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module pwt_front
  import pwt_pkg::*;
#(
  parameter int BITS_W = 11
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [KIND_W-1:0] in_kind,
  input  wire logic [BITS_W-1:0] in_bits,
  output pwt_cmd_t               cmd,
  output logic [BITS_W-1:0]      cmd_bits,
  input  wire logic              cmd_take
);

  localparam int DEPTH = 2;

  pwt_kind_e         kind_mem [DEPTH];
  logic [BITS_W-1:0] bits_mem [DEPTH];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic              pop;
  pwt_kind_e         in_class;

  // Classify the incoming kind code
  always_comb begin
    unique case (in_kind)
      KIND_WRITE: in_class = KIND_WRITE;
      KIND_LOW:   in_class = KIND_LOW;
      KIND_HIGH:  in_class = KIND_HIGH;
      default:    in_class = KIND_TICK;
    endcase
  end

  assign in_ready = (count != 2'(DEPTH));
  assign push     = in_valid && in_ready;
  assign pop      = cmd.valid && cmd_take;

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      kind_mem[wr_ptr] <= in_class;
      bits_mem[wr_ptr] <= in_bits;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign cmd.valid = (count != 2'd0);
  assign cmd.kind  = kind_mem[rd_ptr];
  assign cmd_bits  = bits_mem[rd_ptr];

endmodule

`default_nettype wire

/* rtl/pwt_back.sv */
// ----------------------------------------------------------------------------
// pwt_back: line sequencer and result register
// Runs one queued word per cycle, when the result register has room, through
// the pulse-width line sequencer and holds the output word until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pwt_back
  import pwt_pkg::*;
#(
  parameter int BITS_W = 11,
  parameter int CNT_W  = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pwt_cfg_t          cfg,
  input  wire pwt_cmd_t          cmd,
  input  wire logic [BITS_W-1:0] cmd_bits,
  output logic                   cmd_take,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [OUT_W-1:0]       out_data
);

  pwt_phase_e        phase;
  pwt_phase_e        phase_next;
  logic              level;
  logic              level_next;
  logic [BITS_W-1:0] shift;
  logic [BITS_W-1:0] shift_next;
  logic [CNT_W-1:0]  bits_left;
  logic [CNT_W-1:0]  bits_left_next;
  logic [TICK_W-1:0] ticks_left;
  logic [TICK_W-1:0] ticks_next;
  logic              rej;
  logic              seg_end;
  logic              is_idle;
  logic [TICK_W-1:0] unit_len;
  logic [TICK_W-1:0] long_len;
  logic [TICK_W-1:0] idle_len;

  // Segment lengths; a zero setting counts as one tick
  assign unit_len = (cfg.unit_ticks == '0) ? TICK_W'(1) : TICK_W'(cfg.unit_ticks);
  assign long_len = {unit_len[TICK_W-3:0], 2'b00};
  assign idle_len = (cfg.idle_ticks == '0) ? TICK_W'(1) : cfg.idle_ticks;

  assign is_idle  = (phase == PH_IDLE);
  assign seg_end  = (ticks_left <= TICK_W'(1));
  assign cmd_take = cmd.valid && (!out_valid || out_ready);

  // Next phase of the sequencer
  always_comb begin
    phase_next = phase;
    if (cmd_take) begin
      if (cmd.kind == KIND_TICK) begin
        if (!is_idle && seg_end) begin
          unique case (phase)
            PH_HIGH: phase_next = PH_LOW;
            PH_LOW:  phase_next = (bits_left > CNT_W'(1)) ? PH_HIGH : PH_HOLD;
            default: phase_next = PH_IDLE;
          endcase
        end
      end else if (is_idle) begin
        phase_next = (cmd.kind == KIND_WRITE) ? PH_HIGH : PH_HOLD;
      end
    end
  end

  // Line level, shift register and counters
  always_comb begin
    level_next     = level;
    shift_next     = shift;
    bits_left_next = bits_left;
    ticks_next     = ticks_left;
    rej            = 1'b0;
    if (cmd_take) begin
      if (cmd.kind == KIND_TICK) begin
        if (!is_idle) begin
          if (!seg_end) begin
            ticks_next = ticks_left - TICK_W'(1);
          end else begin
            unique case (phase)
              PH_HIGH: begin
                level_next = 1'b0;
                ticks_next = shift[0] ? unit_len : long_len;
              end
              PH_LOW: begin
                shift_next     = shift >> 1;
                bits_left_next = bits_left - CNT_W'(1);
                if (bits_left > CNT_W'(1)) begin
                  level_next = 1'b1;
                  ticks_next = shift[1] ? long_len : unit_len;
                end else begin
                  ticks_next = idle_len;
                end
              end
              default: ticks_next = '0;
            endcase
          end
        end
      end else if (!is_idle) begin
        rej = 1'b1;
      end else begin
        unique case (cmd.kind)
          KIND_WRITE: begin
            shift_next     = cmd_bits;
            bits_left_next = CNT_W'(BITS_W + 1);
            level_next     = 1'b1;
            ticks_next     = cmd_bits[0] ? long_len : unit_len;
          end
          KIND_LOW: begin
            level_next = 1'b0;
            ticks_next = idle_len;
          end
          default: begin
            level_next = 1'b1;
            ticks_next = idle_len;
          end
        endcase
      end
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      level      <= 1'b0;
      bits_left  <= '0;
      ticks_left <= '0;
    end else begin
      phase      <= phase_next;
      level      <= level_next;
      bits_left  <= bits_left_next;
      ticks_left <= ticks_next;
    end
  end

  always_ff @(posedge clk) begin
    shift <= shift_next;
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      out_data <= {{(OUT_W-3){1'b0}}, rej, (phase_next != PH_IDLE), level_next};
    end
  end

endmodule

`default_nettype wire

/* rtl/pulse_width_single_wire_transmitter.sv */
// A word's result is registered as the word leaves the queue.
// Throughput: one word per cycle unless stalled; every tick or command is a sequencer step.
// A two-word queue lets the input side keep accepting while the result register is stalled.
// Reset (rst, synchronous): line low, sequencer idle, queue and result register empty,
// unit_ticks back to 7 and idle_ticks back to 110.
// ----------------------------------------------------------------------------
// pulse_width_single_wire_transmitter: pulse-width single-wire line driver
// Turns tick, write, reset-low and exec-high words into the level of one
// output line, with one result word for every input word.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_width_single_wire_transmitter
  import pwt_pkg::*;
#(
  parameter int ADDR_BITS = 3,
  parameter int DATA_BITS = 8
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      s_tvalid,
  output logic                                           s_tready,
  // Fields from bit 0 up: reg_addr, reg_value, zero fill
  input  wire logic [((ADDR_BITS+DATA_BITS+7)/8)*8-1:0] s_tdata,
  // Fields from bit 0 up: kind
  input  wire logic [KIND_W-1:0]                         s_tuser,
  output logic                                           m_tvalid,
  input  wire logic                                      m_tready,
  // Fields from bit 0 up: line_level, busy_res, rejected, zero fill
  output logic [OUT_W-1:0]                               m_tdata,
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire logic [CIDX_W-1:0]                         cfg_index,
  input  wire logic [CDATA_W-1:0]                        cfg_data
);

  localparam int BITS_W = ADDR_BITS + DATA_BITS;
  localparam int CNT_W  = $clog2(BITS_W + 2);

  pwt_cfg_t          cfg;
  pwt_cmd_t          cmd;
  logic [BITS_W-1:0] cmd_bits;
  logic              cmd_take;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unit_ticks <= UNIT_TICKS_RST;
      cfg.idle_ticks <= IDLE_TICKS_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_UNIT_TICKS) begin
        cfg.unit_ticks <= cfg_data[UNIT_W-1:0];
      end else if (cfg_index == CFG_IDLE_TICKS) begin
        cfg.idle_ticks <= cfg_data[IDLE_W-1:0];
      end
    end
  end

  // Front part: classify and queue
  pwt_front #(
    .BITS_W(BITS_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_kind  (s_tuser),
    .in_bits  (s_tdata[BITS_W-1:0]),
    .cmd      (cmd),
    .cmd_bits (cmd_bits),
    .cmd_take (cmd_take)
  );

  // Back part: line sequencer and result register
  pwt_back #(
    .BITS_W(BITS_W),
    .CNT_W (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_bits  (cmd_bits),
    .cmd_take  (cmd_take),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

`ifndef SYNTHESIS
  // A dropped command leaves the sequencer busy
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1])
    else $error("rejected word reports an idle line");

  // The input side only stalls when the queue holds words
  a_stall_queue: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> cmd.valid)
    else $error("input stalled with an empty queue");

  // A word leaves the queue only when the result register can hold its result
  a_take_room: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> m_tvalid)
    else $error("queue word taken without a result");
`endif

endmodule

`default_nettype wire
